// ===== sv/fhlt_pkg.sv =====
// Shared types and codes for the free-list handle table.
`timescale 1ns / 1ps

package fhlt_pkg;

    // Request kinds carried on the kind field.
    typedef enum logic [2:0] {
        K_ALLOC = 3'd0,
        K_FREE  = 3'd1,
        K_READ  = 3'd2,
        K_WRITE = 3'd3,
        K_DUP   = 3'd4,
        K_CLEAR = 3'd5
    } t_kind;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    // Write strobes from the control logic to the two storage arrays.
    typedef struct packed {
        logic value_we;
        logic link_we;
    } t_mem_wr;

endpackage

// ===== sv/fhlt_ram.sv =====
// Simple dual-port memory with one write port and one registered read port.
`timescale 1ns / 1ps

module fhlt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data registered.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/fhlt_core.sv =====
// Slot valid bits, free-list head, counters, request decode and result register.
`timescale 1ns / 1ps

module fhlt_core import fhlt_pkg::*; #(
    parameter int SLOTS      = 256,
    parameter int VALUE_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_exec,
    input  logic [2:0]               i_kind,
    input  logic [7:0]               i_slot,
    input  logic [31:0]              i_value,
    input  logic [VALUE_BITS-1:0]    i_value_rdata,
    input  logic [$clog2(SLOTS)-1:0] i_link_rdata,
    output logic [$clog2(SLOTS)-1:0] o_free_head,
    output t_mem_wr                  o_wr,
    output logic [$clog2(SLOTS)-1:0] o_value_waddr,
    output logic [VALUE_BITS-1:0]    o_value_wdata,
    output logic [$clog2(SLOTS)-1:0] o_link_waddr,
    output logic [$clog2(SLOTS)-1:0] o_link_wdata,
    output logic                     o_valid,
    output logic [7:0]               o_new_slot,
    output logic [31:0]              o_read_value,
    output logic [1:0]               o_status,
    output logic [8:0]               o_live_count
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int AW = (SW > 8) ? SW : 8;

    logic [SLOTS-1:0] r_slot_valid;
    logic [SW-1:0]    r_free_head;
    logic [CW-1:0]    r_fresh_next;
    logic [CW-1:0]    r_valid_total;

    logic [SW-1:0]    n_free_head;
    logic [CW-1:0]    n_fresh_next;
    logic [CW-1:0]    n_valid_total;

    logic             r_res_valid;
    logic [7:0]       r_new_slot;
    logic [31:0]      r_read_value;
    t_status          r_status;
    logic [8:0]       r_live_count;

    logic [AW:0]           slot_wide;
    logic [SW-1:0]         idx;
    logic                  live;
    logic                  list_ne;
    logic                  can_take;
    logic [SW-1:0]         got;
    logic                  take;
    logic                  do_clear;
    logic                  do_free;
    logic [VALUE_BITS-1:0] copy;
    logic [7:0]            res_new_slot;
    logic [31:0]           res_read_value;
    t_status               res_status;

    // Address decode and slot liveness.
    assign slot_wide = (AW + 1)'(i_slot);
    assign idx       = slot_wide[SW-1:0];
    assign live      = (slot_wide < (AW + 1)'(SLOTS)) && r_slot_valid[idx];

    // Free list is non-empty whenever some used slot is not live.
    assign list_ne  = (r_fresh_next != r_valid_total);
    assign can_take = list_ne || (r_fresh_next != CW'(SLOTS));
    assign got      = list_ne ? r_free_head : r_fresh_next[SW-1:0];
    assign copy     = live ? i_value_rdata : '0;

    // Request decode: storage writes, state updates and the result fields.
    always_comb begin
        take           = 1'b0;
        do_clear       = 1'b0;
        do_free        = 1'b0;
        o_wr           = '0;
        o_value_waddr  = got;
        o_value_wdata  = VALUE_BITS'(i_value);
        res_new_slot   = '0;
        res_read_value = '0;
        res_status     = ST_OK;
        case (i_kind)
            K_ALLOC: begin
                if (can_take) begin
                    take         = 1'b1;
                    o_wr.value_we = 1'b1;
                    res_new_slot = 8'(got);
                end else begin
                    res_status = ST_FULL;
                end
            end
            K_FREE: begin
                if (live) begin
                    do_free      = 1'b1;
                    o_wr.link_we = 1'b1;
                end else begin
                    res_status = ST_INVALID;
                end
            end
            K_READ: begin
                if (live) begin
                    res_read_value = 32'(i_value_rdata);
                end else begin
                    res_status = ST_INVALID;
                end
            end
            K_WRITE: begin
                if (live) begin
                    o_wr.value_we = 1'b1;
                    o_value_waddr = idx;
                end else begin
                    res_status = ST_INVALID;
                end
            end
            K_DUP: begin
                o_value_wdata = copy;
                if (can_take) begin
                    take          = 1'b1;
                    o_wr.value_we = 1'b1;
                    res_new_slot  = 8'(got);
                    res_status    = live ? ST_OK : ST_INVALID;
                end else begin
                    res_status = ST_FULL;
                end
            end
            K_CLEAR: begin
                do_clear = 1'b1;
            end
            default: begin
            end
        endcase
        if (!i_exec) begin
            o_wr = '0;
        end
    end

    assign o_link_waddr = idx;
    assign o_link_wdata = r_free_head;

    // Next values of the free-list head and the two counters.
    always_comb begin
        n_free_head   = r_free_head;
        n_fresh_next  = r_fresh_next;
        n_valid_total = r_valid_total;
        if (do_clear) begin
            n_free_head   = '0;
            n_fresh_next  = '0;
            n_valid_total = '0;
        end else if (do_free) begin
            n_free_head   = idx;
            n_valid_total = r_valid_total - CW'(1);
        end else if (take) begin
            if (list_ne) begin
                n_free_head = i_link_rdata;
            end else begin
                n_fresh_next = r_fresh_next + CW'(1);
            end
            n_valid_total = r_valid_total + CW'(1);
        end
    end

    // State registers, updated only in the execute cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid  <= '0;
            r_free_head   <= '0;
            r_fresh_next  <= '0;
            r_valid_total <= '0;
        end else if (i_exec) begin
            r_free_head   <= n_free_head;
            r_fresh_next  <= n_fresh_next;
            r_valid_total <= n_valid_total;
            if (do_clear) begin
                r_slot_valid <= '0;
            end else if (do_free) begin
                r_slot_valid[idx] <= 1'b0;
            end else if (take) begin
                r_slot_valid[got] <= 1'b1;
            end
        end
    end

    // Result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= i_exec;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_exec) begin
            r_new_slot   <= res_new_slot;
            r_read_value <= res_read_value;
            r_status     <= res_status;
            r_live_count <= 9'(n_valid_total);
        end
    end

    assign o_free_head  = r_free_head;
    assign o_valid      = r_res_valid;
    assign o_new_slot   = r_new_slot;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_live_count = r_live_count;

endmodule

// ===== sv/free_list_handle_table_unit.sv =====
// Top level of the free-list handle table: request register, storage and control.
//
//   Channel   Direction  Handshake            Fields
//   request   in         start, busy          i_kind, i_slot, i_value
//   result    out        o_valid (one cycle)  o_new_slot, o_read_value, o_status,
//                                             o_live_count
//
// A request is taken when start is high and busy is low. The capture edge registers
// it and launches the registered reads of the value and link memories; the execute
// step then performs the update and registers the result. busy is high for a single
// cycle, during the execute step, so a new request is taken only once the previous one
// has been executed. The result strobe o_valid is high for one cycle, in the cycle after
// the update. Reset is synchronous and clears the valid bits, counters and handshake;
// no clearing pass over the memories is needed.
`timescale 1ns / 1ps

module free_list_handle_table_unit import fhlt_pkg::*; #(
    parameter int SLOTS      = 256,
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_kind,
    input  logic [7:0]  i_slot,
    input  logic [31:0] i_value,
    output logic        o_valid,
    output logic [7:0]  o_new_slot,
    output logic [31:0] o_read_value,
    output logic [1:0]  o_status,
    output logic [8:0]  o_live_count
);

    localparam int SW = $clog2(SLOTS);
    localparam int AW = (SW > 8) ? SW : 8;

    logic                  r_busy;
    logic                  n_busy;
    logic [2:0]            r_kind;
    logic [7:0]            r_slot;
    logic [31:0]           r_value;

    logic                  accept;
    logic [AW:0]           rd_slot_wide;
    logic [VALUE_BITS-1:0] value_rdata;
    logic [SW-1:0]         link_rdata;
    logic [SW-1:0]         free_head;
    t_mem_wr               wr;
    logic [SW-1:0]         value_waddr;
    logic [VALUE_BITS-1:0] value_wdata;
    logic [SW-1:0]         link_waddr;
    logic [SW-1:0]         link_wdata;

    assign accept       = start && !r_busy;
    assign n_busy       = accept;
    assign rd_slot_wide = (AW + 1)'(i_slot);

    // Busy covers the execute cycle of each request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    // Request register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= i_kind;
            r_slot  <= i_slot;
            r_value <= i_value;
        end
    end

    // Stored slot values, read at the addressed slot.
    fhlt_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (SLOTS)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (wr.value_we),
        .i_waddr (value_waddr),
        .i_wdata (value_wdata),
        .i_re    (accept),
        .i_raddr (rd_slot_wide[SW-1:0]),
        .o_rdata (value_rdata)
    );

    // Free-list links, read at the current list head.
    fhlt_ram #(
        .WIDTH (SW),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (wr.link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (accept),
        .i_raddr (free_head),
        .o_rdata (link_rdata)
    );

    // Control and result register.
    fhlt_core #(
        .SLOTS      (SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_exec        (r_busy),
        .i_kind        (r_kind),
        .i_slot        (r_slot),
        .i_value       (r_value),
        .i_value_rdata (value_rdata),
        .i_link_rdata  (link_rdata),
        .o_free_head   (free_head),
        .o_wr          (wr),
        .o_value_waddr (value_waddr),
        .o_value_wdata (value_wdata),
        .o_link_waddr  (link_waddr),
        .o_link_wdata  (link_wdata),
        .o_valid       (o_valid),
        .o_new_slot    (o_new_slot),
        .o_read_value  (o_read_value),
        .o_status      (o_status),
        .o_live_count  (o_live_count)
    );

    assign busy = r_busy;

endmodule

// ===== sv/fhlt_checker.sv =====
// Port-level assertions for the free-list handle table, bound to the top level.
`timescale 1ns / 1ps

module fhlt_checker import fhlt_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [7:0]  o_new_slot,
    input logic [31:0] o_read_value,
    input logic [1:0]  o_status
);

    logic accept;

    assign accept = start && !busy;

    // A taken request raises busy in the following cycle, holding off the next one.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after a request was taken");

    // Every taken request is followed by its result strobe, after the execute cycle.
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##2 o_valid)
        else $error("result strobe missing two cycles after a request");

    // A result only appears once the execute cycle is over.
    a_result_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy && $past(busy))
        else $error("result strobe without a preceding execute cycle");

    // A full table hands out no slot and returns no data.
    a_full_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL) |-> (o_new_slot == '0) && (o_read_value == '0))
        else $error("table full result carries a slot or data");

    // The status field carries one of the defined codes.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK) || (o_status == ST_FULL)
                    || (o_status == ST_INVALID))
        else $error("undefined status code on a result");

endmodule

bind free_list_handle_table_unit fhlt_checker u_fhlt_checker (.*);

// ===== test/tb_free_list_handle_table_unit.sv =====
// Self-checking testbench for the free-list handle table unit.
`timescale 1ns / 1ps

module tb_free_list_handle_table_unit;
    import fhlt_pkg::*;

    localparam int unsigned TABLE_SLOTS = 256;

    // Request kinds that the block ignores.
    localparam logic [2:0] K_SPARE_LO = 3'd6;
    localparam logic [2:0] K_SPARE_HI = 3'd7;

    // One request waiting to be driven, with the idle gap that follows it.
    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  slot;
        logic [31:0] word;
        bit          pick_live;
        int unsigned gap;
        bit          drain;
    } t_planned_req;

    // One predicted result of the table.
    typedef struct {
        logic [7:0]  new_slot;
        logic [31:0] read_value;
        t_status     status;
        logic [8:0]  live_count;
    } t_table_result;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    logic [2:0]  i_kind  = '0;
    logic [7:0]  i_slot  = '0;
    logic [31:0] i_value = '0;
    logic        o_valid;
    logic [7:0]  o_new_slot;
    logic [31:0] o_read_value;
    logic [1:0]  o_status;
    logic [8:0]  o_live_count;

    t_planned_req  pending_reqs[$];
    t_table_result results_due[$];
    int unsigned   planned_total = 0;
    int unsigned   taken_total   = 0;
    int unsigned   mismatches    = 0;
    int unsigned   gap_left      = 0;

    // Shadow copy of the table contents, free list and counters.
    logic [31:0] tbl_value [TABLE_SLOTS];
    logic [8:0]  tbl_link  [TABLE_SLOTS];
    logic        tbl_live  [TABLE_SLOTS];
    logic [8:0]  tbl_head;
    logic [8:0]  tbl_fresh;
    logic [8:0]  tbl_total;

    free_list_handle_table_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_slot       (i_slot),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .o_new_slot   (o_new_slot),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_live_count (o_live_count)
    );

    // Free-running clock with a 12 ns period.
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Takes the most recently freed slot, else the lowest slot never used.
    function automatic bit claim_slot(input logic [31:0] word, output logic [7:0] got);
        logic [7:0] s;
        got = '0;
        if (tbl_fresh != tbl_total) begin
            s = tbl_head[7:0];
            tbl_head = tbl_link[s];
        end else if (tbl_fresh < TABLE_SLOTS) begin
            s = tbl_fresh[7:0];
            tbl_fresh = tbl_fresh + 9'd1;
        end else begin
            return 1'b0;
        end
        tbl_value[s] = word;
        tbl_live[s] = 1'b1;
        tbl_total = tbl_total + 9'd1;
        got = s;
        return 1'b1;
    endfunction

    // Applies one request to the shadow table and returns the result it gives.
    function automatic t_table_result table_response(input logic [2:0] kind,
                                                     input logic [7:0] slot,
                                                     input logic [31:0] word);
        t_table_result r;
        logic [7:0]    got;
        logic          src_ok;
        logic [31:0]   copy;
        int            i;
        r.new_slot   = '0;
        r.read_value = '0;
        r.status     = ST_OK;
        case (kind)
            K_ALLOC: begin
                if (claim_slot(word, got)) r.new_slot = got;
                else r.status = ST_FULL;
            end
            K_FREE: begin
                if (tbl_live[slot]) begin
                    tbl_live[slot] = 1'b0;
                    tbl_link[slot] = tbl_head;
                    tbl_head = {1'b0, slot};
                    tbl_total = tbl_total - 9'd1;
                end else begin
                    r.status = ST_INVALID;
                end
            end
            K_READ: begin
                if (tbl_live[slot]) r.read_value = tbl_value[slot];
                else r.status = ST_INVALID;
            end
            K_WRITE: begin
                if (tbl_live[slot]) tbl_value[slot] = word;
                else r.status = ST_INVALID;
            end
            K_DUP: begin
                // An invalid source still takes a slot, holding the empty value.
                src_ok = tbl_live[slot];
                copy = src_ok ? tbl_value[slot] : '0;
                if (claim_slot(copy, got)) begin
                    r.new_slot = got;
                    if (!src_ok) r.status = ST_INVALID;
                end else begin
                    r.status = ST_FULL;
                end
            end
            K_CLEAR: begin
                for (i = 0; i < TABLE_SLOTS; i++) tbl_live[i] = 1'b0;
                tbl_head  = '0;
                tbl_fresh = '0;
                tbl_total = '0;
            end
            default: begin
            end
        endcase
        r.live_count = tbl_total;
        return r;
    endfunction

    // Picks a slot that is valid at present, if there is one.
    function automatic logic [7:0] live_slot();
        logic [7:0] probe;
        int         i;
        probe = 8'($urandom_range(0, TABLE_SLOTS - 1));
        for (i = 0; i < TABLE_SLOTS; i++) begin
            if (tbl_live[probe]) return probe;
            probe = probe + 8'd1;
        end
        return probe;
    endfunction

    // Mostly short gaps, a few long ones; none at all in a steady stretch.
    function automatic int unsigned random_gap(input bit steady);
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random handle word, with the empty value and all ones now and then.
    function automatic logic [31:0] random_word();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    // Request kind for general traffic, weighted towards allocation.
    function automatic logic [2:0] mixed_kind();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30) return K_ALLOC;
        if (r < 45) return K_FREE;
        if (r < 63) return K_READ;
        if (r < 77) return K_WRITE;
        if (r < 93) return K_DUP;
        if (r < 94) return K_CLEAR;
        if (r < 97) return K_SPARE_LO;
        return K_SPARE_HI;
    endfunction

    task automatic plan(input logic [2:0] kind, input logic [7:0] slot, input logic [31:0] word,
                        input bit pick_live, input int unsigned gap, input bit drain);
        t_planned_req r;
        r.kind      = kind;
        r.slot      = slot;
        r.word      = word;
        r.pick_live = pick_live;
        r.gap       = gap;
        r.drain     = drain;
        pending_reqs.push_back(r);
        planned_total++;
    endtask

    // Request driver: predicts each accepted request, then presents the next one.
    always @(posedge i_clk) begin : request_driver
        t_planned_req nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                results_due.push_back(table_response(i_kind, i_slot, i_value));
                taken_total++;
            end
            // A request refused by busy is held unchanged.
            if (!(start && busy)) begin
                if (gap_left != 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_reqs.size() != 0 &&
                             !(pending_reqs[0].drain && results_due.size() != 0)) begin
                    nxt = pending_reqs.pop_front();
                    i_kind  <= nxt.kind;
                    i_slot  <= nxt.pick_live ? live_slot() : nxt.slot;
                    i_value <= nxt.word;
                    gap_left = nxt.gap;
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Result checker: each strobed result is compared with the oldest prediction.
    always @(posedge i_clk) begin : result_checker
        t_table_result want;
        if (i_rst_n && o_valid) begin
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result: new_slot %0d read_value %h status %0d live %0d",
                         $time, o_new_slot, o_read_value, o_status, o_live_count);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                if (o_new_slot !== want.new_slot) begin
                    $display("%0t: new_slot expected %0d actual %0d",
                             $time, want.new_slot, o_new_slot);
                    mismatches++;
                end
                if (o_read_value !== want.read_value) begin
                    $display("%0t: read_value expected %h actual %h",
                             $time, want.read_value, o_read_value);
                    mismatches++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    mismatches++;
                end
                if (o_live_count !== want.live_count) begin
                    $display("%0t: live_count expected %0d actual %0d",
                             $time, want.live_count, o_live_count);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus plan, reset and end of run.
    initial begin : run_sequence
        int n;
        for (n = 0; n < TABLE_SLOTS; n++) tbl_live[n] = 1'b0;
        tbl_head  = '0;
        tbl_fresh = '0;
        tbl_total = '0;

        // Directed requests: invalid slots on an empty table, duplicate of an
        // invalid source, extreme words, reuse of freed slots in last-in order,
        // the ignored kinds and a clear.
        plan(K_READ,     8'd0,   '0,            0, random_gap(0), 0);
        plan(K_FREE,     8'd255, '1,            0, random_gap(0), 0);
        plan(K_WRITE,    8'd7,   32'h1234_5678, 0, random_gap(0), 0);
        plan(K_DUP,      8'd3,   '0,            0, random_gap(0), 0);
        plan(K_ALLOC,    8'd255, '1,            0, random_gap(0), 0);
        plan(K_ALLOC,    8'd0,   '0,            0, random_gap(0), 0);
        plan(K_READ,     8'd1,   '0,            0, random_gap(0), 0);
        plan(K_READ,     8'd0,   '1,            0, random_gap(0), 0);
        plan(K_WRITE,    8'd2,   32'hA5A5_5A5A, 0, random_gap(0), 0);
        plan(K_DUP,      8'd1,   '0,            0, random_gap(0), 0);
        plan(K_READ,     8'd3,   '0,            0, random_gap(0), 0);
        plan(K_FREE,     8'd1,   '0,            0, random_gap(0), 0);
        plan(K_FREE,     8'd3,   '0,            0, random_gap(0), 0);
        plan(K_FREE,     8'd3,   '0,            0, random_gap(0), 0);
        plan(K_ALLOC,    8'd0,   32'h8000_0001, 0, random_gap(0), 0);
        plan(K_ALLOC,    8'd0,   32'h7FFF_FFFE, 0, random_gap(0), 0);
        plan(K_ALLOC,    8'd0,   32'h0000_0001, 0, random_gap(0), 0);
        plan(K_SPARE_LO, 8'd4,   '1,            0, random_gap(0), 0);
        plan(K_SPARE_HI, 8'd255, '1,            0, random_gap(0), 0);
        plan(K_CLEAR,    8'd0,   '0,            0, random_gap(0), 1);
        plan(K_READ,     8'd2,   '0,            0, random_gap(0), 0);
        plan(K_ALLOC,    8'd0,   32'hDEAD_BEEF, 0, random_gap(0), 0);
        plan(K_READ,     8'd0,   '0,            0, random_gap(0), 0);

        // General traffic, mostly on valid slots, ending in a steady stretch.
        for (n = 0; n < 150; n++)
            plan(mixed_kind(), 8'($urandom), random_word(), $urandom_range(0, 9) != 0,
                 random_gap(n >= 110), 0);

        // Fill the table until it reports full, with some duplicates of live slots.
        for (n = 0; n < 265; n++)
            plan(($urandom_range(0, 4) == 0) ? K_DUP : K_ALLOC, 8'($urandom), random_word(),
                 1, random_gap(n < 120), n == 0);

        // Release part of it again, with reads in between.
        for (n = 0; n < 110; n++)
            plan(($urandom_range(0, 3) == 0) ? K_READ : K_FREE, 8'($urandom), random_word(),
                 $urandom_range(0, 19) != 0, random_gap(0), 0);

        for (n = 0; n < 150; n++)
            plan(mixed_kind(), 8'($urandom), random_word(), $urandom_range(0, 9) != 0,
                 random_gap(0), 0);

        plan(K_CLEAR, 8'($urandom), random_word(), 0, random_gap(0), 1);

        for (n = 0; n < 250; n++)
            plan(mixed_kind(), 8'($urandom), random_word(), $urandom_range(0, 9) != 0,
                 random_gap(n >= 200), 0);

        // Hold reset, then release it.
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (taken_total < planned_total) @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("tb_free_list_handle_table_unit: clean");
        end else begin
            $display("tb_free_list_handle_table_unit: errors");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("tb_free_list_handle_table_unit: errors");
        $finish;
    end

endmodule
